// ===== design/tmef_pkg.sv =====
// Shared types, codes and helpers of the triangle mesh edge flip/split block.
package tmef_pkg;

	localparam int MAX_TRIANGLES = 1024;
	localparam int VERTEX_BITS   = 16;
	localparam int IDX_W         = $clog2(MAX_TRIANGLES);
	localparam int CNT_W         = IDX_W + 1;
	localparam int LINK_W        = 11;

	localparam logic [1:0] NO_FACE = 2'd3;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_FLIP  = 2'd2;
	localparam logic [1:0] OP_SPLIT = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INDEX    = 3'd1;
	localparam logic [2:0] ST_BOUNDARY = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_BACKLINK = 3'd4;

	// memory address selects
	localparam logic [2:0] AS_T  = 3'd0;
	localparam logic [2:0] AS_R  = 3'd1;
	localparam logic [2:0] AS_O1 = 3'd2;
	localparam logic [2:0] AS_O2 = 3'd3;
	localparam logic [2:0] AS_N  = 3'd4;
	localparam logic [2:0] AS_N1 = 3'd5;

	// memory write data selects
	localparam logic [2:0] WS_LOAD = 3'd0;
	localparam logic [2:0] WS_FT   = 3'd1;
	localparam logic [2:0] WS_FR   = 3'd2;
	localparam logic [2:0] WS_ST   = 3'd3;
	localparam logic [2:0] WS_SN   = 3'd4;
	localparam logic [2:0] WS_SN1  = 3'd5;
	localparam logic [2:0] WS_P1   = 3'd6;
	localparam logic [2:0] WS_P2   = 3'd7;

	typedef logic [VERTEX_BITS-1:0] vert_t;
	typedef logic [LINK_W-1:0]      link_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	typedef struct packed {
		vert_t [2:0] v;
		link_t [2:0] l;
	} row_t;

	typedef struct packed {
		logic [1:0]       operation;
		logic [IDX_W-1:0] tri_index;
		logic [1:0]       local_face;
		vert_t            new_vertex;
		vert_t            load_vert0;
		vert_t            load_vert1;
		vert_t            load_vert2;
		link_t            load_link0;
		link_t            load_link1;
		link_t            load_link2;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		cnt_t       count_now;
		vert_t      out_vert0;
		vert_t      out_vert1;
		vert_t      out_vert2;
		link_t      out_link0;
		link_t      out_link1;
		link_t      out_link2;
	} rsp_t;

	typedef struct packed {
		logic       accept;
		logic       mem_rd;
		logic       mem_wr;
		logic [2:0] addr_sel;
		logic [2:0] wd_sel;
		logic       cap_t;
		logic       cap_r;
		logic       cap_fa;
		logic       cap_fc;
		logic       tgt_r;
		logic       res_ok;
		logic       res_err;
		logic [2:0] err_code;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       full_ld;
		logic       idx_bad;
		logic       room_bad;
		logic       f_bad;
		logic       r_neg;
		logic       r_bad;
		logic       face_none;
		logic       o1_neg;
		logic       o1_bad;
		logic       o2_neg;
		logic       o2_bad;
		logic       out_free;
	} sts_t;

	function automatic logic [1:0] inc3(logic [1:0] x);
		return (x == 2'd2) ? 2'd0 : x + 2'd1;
	endfunction

	// first face (lowest) whose link equals tgt
	function automatic logic [1:0] face_of(row_t row, link_t tgt);
		logic [1:0] res;
		res = NO_FACE;
		for (int k = 2; k >= 0; k--) begin
			if (row.l[k] == tgt) res = 2'(k);
		end
		return res;
	endfunction

	// non-negative link not below the count
	function automatic logic link_bad(link_t x, cnt_t cnt);
		return !x[LINK_W-1] && (CNT_W'(x) >= cnt);
	endfunction

endpackage

// ===== design/tmef_req_if.sv =====
// Request channel of the mesh block.
interface tmef_req_if import tmef_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/tmef_rsp_if.sv =====
// Response channel of the mesh block.
interface tmef_rsp_if import tmef_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/tmef_datapath.sv =====
// Mesh table memory, working registers, checks and response register.
module tmef_datapath import tmef_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  req_t            req_data,
	input  cmd_t            cmd,
	output sts_t            sts,
	tmef_rsp_if.source      rsp
);

	row_t mem [MAX_TRIANGLES];
	row_t rd_q;

	logic [1:0]       op_q;
	logic [IDX_W-1:0] t_q;
	logic [1:0]       f_q;
	vert_t            p_q;
	row_t             ld_q;
	cnt_t             count_q;
	row_t             trow_q;
	row_t             rrow_q;
	logic [1:0]       j_q;
	logic [1:0]       fa_q;
	logic [1:0]       fc_q;
	logic             out_valid_q;
	rsp_t             out_q;

	logic [1:0] fi, f1, f2, j1, j2;
	link_t r, a, b, c, d, o1, o2, t_link, n_link, n1_link, tgt;
	vert_t v0, v1, v2, pv;
	logic flip;
	logic [IDX_W-1:0] addr;
	row_t wdata;
	cnt_t inc;
	logic out_free;

	assign flip    = (op_q == OP_FLIP);
	assign fi      = (f_q == NO_FACE) ? 2'd0 : f_q;
	assign f1      = inc3(fi);
	assign f2      = inc3(f1);
	assign j1      = inc3(j_q);
	assign j2      = inc3(j1);
	assign r       = trow_q.l[fi];
	assign a       = trow_q.l[f1];
	assign b       = trow_q.l[f2];
	assign v0      = trow_q.v[fi];
	assign v1      = trow_q.v[f1];
	assign v2      = trow_q.v[f2];
	assign pv      = rrow_q.v[j2];
	assign c       = rrow_q.l[j1];
	assign d       = rrow_q.l[j2];
	assign o1      = flip ? a : trow_q.l[1];
	assign o2      = flip ? c : trow_q.l[2];
	assign t_link  = LINK_W'(t_q);
	assign n_link  = LINK_W'(count_q);
	assign n1_link = LINK_W'(count_q + CNT_W'(1));
	assign tgt     = cmd.tgt_r ? r : t_link;
	assign out_free = !out_valid_q || rsp.ready;

	assign sts.op        = op_q;
	assign sts.full_ld   = (count_q >= CNT_W'(MAX_TRIANGLES));
	assign sts.idx_bad   = (CNT_W'(t_q) >= count_q);
	assign sts.room_bad  = ({1'b0, count_q} + (CNT_W+1)'(2)) > (CNT_W+1)'(MAX_TRIANGLES);
	assign sts.f_bad     = (f_q == NO_FACE);
	assign sts.r_neg     = r[LINK_W-1];
	assign sts.r_bad     = link_bad(r, count_q);
	assign sts.face_none = (face_of(rd_q, tgt) == NO_FACE);
	assign sts.o1_neg    = o1[LINK_W-1];
	assign sts.o1_bad    = link_bad(o1, count_q);
	assign sts.o2_neg    = o2[LINK_W-1];
	assign sts.o2_bad    = link_bad(o2, count_q);
	assign sts.out_free  = out_free;

	always_comb begin
		unique case (cmd.addr_sel)
			AS_T:    addr = t_q;
			AS_R:    addr = r[IDX_W-1:0];
			AS_O1:   addr = o1[IDX_W-1:0];
			AS_O2:   addr = o2[IDX_W-1:0];
			AS_N:    addr = count_q[IDX_W-1:0];
			AS_N1:   addr = n1_link[IDX_W-1:0];
			default: addr = t_q;
		endcase
	end

	always_comb begin
		wdata = rd_q;
		unique case (cmd.wd_sel)
			WS_LOAD: wdata = ld_q;
			WS_FT: begin
				wdata.v = {v0, v2, pv};
				wdata.l = {c, b, r};
			end
			WS_FR: begin
				wdata.v = {v2, v1, pv};
				wdata.l = {t_link, a, d};
			end
			WS_ST: begin
				wdata.v = {trow_q.v[1], trow_q.v[0], p_q};
				wdata.l = {n_link, trow_q.l[0], n1_link};
			end
			WS_SN: begin
				wdata.v = {trow_q.v[2], trow_q.v[1], p_q};
				wdata.l = {n1_link, trow_q.l[1], t_link};
			end
			WS_SN1: begin
				wdata.v = {trow_q.v[0], trow_q.v[2], p_q};
				wdata.l = {t_link, trow_q.l[2], n_link};
			end
			WS_P1:   wdata.l[fa_q] = flip ? r : n_link;
			WS_P2:   wdata.l[fc_q] = flip ? t_link : n1_link;
			default: wdata = rd_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) mem[addr] <= wdata;
		if (cmd.mem_rd) rd_q <= mem[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q      <= req_data.operation;
			t_q       <= req_data.tri_index;
			f_q       <= req_data.local_face;
			p_q       <= req_data.new_vertex;
			ld_q.v    <= {req_data.load_vert2, req_data.load_vert1, req_data.load_vert0};
			ld_q.l    <= {req_data.load_link2, req_data.load_link1, req_data.load_link0};
		end
		if (cmd.cap_t) trow_q <= rd_q;
		if (cmd.cap_r) begin
			rrow_q <= rd_q;
			j_q    <= face_of(rd_q, t_link);
		end
		if (cmd.cap_fa) fa_q <= face_of(rd_q, t_link);
		if (cmd.cap_fc) fc_q <= face_of(rd_q, tgt);
	end

	always_comb begin
		case (op_q)
			OP_LOAD:  inc = CNT_W'(1);
			OP_SPLIT: inc = CNT_W'(2);
			default:  inc = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.res_ok) count_q <= count_q + inc;
			if (cmd.res_ok || cmd.res_err) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_ok) begin
			out_q.status    <= ST_OK;
			out_q.count_now <= count_q + inc;
			out_q.out_vert0 <= rd_q.v[0];
			out_q.out_vert1 <= rd_q.v[1];
			out_q.out_vert2 <= rd_q.v[2];
			out_q.out_link0 <= rd_q.l[0];
			out_q.out_link1 <= rd_q.l[1];
			out_q.out_link2 <= rd_q.l[2];
		end else if (cmd.res_err) begin
			out_q           <= '0;
			out_q.status    <= cmd.err_code;
			out_q.count_now <= count_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

`ifndef ASSERT_OFF
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mem_rd && cmd.mem_wr))
		else $error("memory read and write in one cycle");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TRIANGLES))
		else $error("triangle count beyond table size");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_ok || cmd.res_err) |-> out_free)
		else $error("response overwrites a pending one");
	a_split_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_ok && op_q == OP_SPLIT) |=> count_q == $past(count_q) + CNT_W'(2))
		else $error("split did not add two entries");
`endif

endmodule

// ===== design/tmef_ctrl.sv =====
// Sequencer for load, read, flip and split over the single-port mesh table.
module tmef_ctrl import tmef_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DISP = 5'd1;
	localparam logic [4:0] S_WLD  = 5'd2;
	localparam logic [4:0] S_RDT  = 5'd3;
	localparam logic [4:0] S_CKT  = 5'd4;
	localparam logic [4:0] S_FCHK = 5'd5;
	localparam logic [4:0] S_SCHK = 5'd6;
	localparam logic [4:0] S_RDR  = 5'd7;
	localparam logic [4:0] S_CKR  = 5'd8;
	localparam logic [4:0] S_O1   = 5'd9;
	localparam logic [4:0] S_CK1  = 5'd10;
	localparam logic [4:0] S_O2   = 5'd11;
	localparam logic [4:0] S_CK2  = 5'd12;
	localparam logic [4:0] S_WT   = 5'd13;
	localparam logic [4:0] S_WN   = 5'd14;
	localparam logic [4:0] S_WN1  = 5'd15;
	localparam logic [4:0] S_WR   = 5'd16;
	localparam logic [4:0] S_P1R  = 5'd17;
	localparam logic [4:0] S_P1W  = 5'd18;
	localparam logic [4:0] S_P2R  = 5'd19;
	localparam logic [4:0] S_P2W  = 5'd20;
	localparam logic [4:0] S_FRD  = 5'd21;
	localparam logic [4:0] S_RES  = 5'd22;
	localparam logic [4:0] S_ERR  = 5'd23;

	logic [4:0] state_q, state_d;
	logic [2:0] err_q, err_d;
	logic       flip;

	assign flip     = (sts.op == OP_FLIP);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		err_d   = err_q;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.accept = 1'b1;
				state_d    = S_DISP;
			end
			S_DISP: begin
				if (sts.op == OP_LOAD) begin
					if (sts.full_ld) begin
						err_d = ST_FULL; state_d = S_ERR;
					end else state_d = S_WLD;
				end else if (sts.idx_bad) begin
					err_d = ST_INDEX; state_d = S_ERR;
				end else state_d = S_RDT;
			end
			S_WLD: begin
				cmd.mem_wr = 1'b1; cmd.addr_sel = AS_N; cmd.wd_sel = WS_LOAD;
				state_d = S_FRD;
			end
			S_RDT: begin
				cmd.mem_rd = 1'b1; cmd.addr_sel = AS_T;
				state_d = S_CKT;
			end
			S_CKT: begin
				cmd.cap_t = 1'b1;
				// a plain read answers straight from the row just fetched
				if (sts.op == OP_READ) state_d = S_RES;
				else if (flip) state_d = S_FCHK;
				else state_d = S_SCHK;
			end
			S_FCHK: begin
				if (sts.f_bad || (!sts.r_neg && sts.r_bad)) begin
					err_d = ST_INDEX; state_d = S_ERR;
				end else if (sts.r_neg) begin
					err_d = ST_BOUNDARY; state_d = S_ERR;
				end else state_d = S_RDR;
			end
			S_SCHK: begin
				if (sts.room_bad) begin
					err_d = ST_FULL; state_d = S_ERR;
				end else state_d = S_O1;
			end
			S_RDR: begin
				cmd.mem_rd = 1'b1; cmd.addr_sel = AS_R;
				state_d = S_CKR;
			end
			S_CKR: begin
				if (sts.face_none) begin
					err_d = ST_BACKLINK; state_d = S_ERR;
				end else begin
					cmd.cap_r = 1'b1; state_d = S_O1;
				end
			end
			S_O1: begin
				if (sts.o1_neg) state_d = S_O2;
				else if (sts.o1_bad) begin
					err_d = ST_INDEX; state_d = S_ERR;
				end else begin
					cmd.mem_rd = 1'b1; cmd.addr_sel = AS_O1; state_d = S_CK1;
				end
			end
			S_CK1: begin
				if (sts.face_none) begin
					err_d = ST_BACKLINK; state_d = S_ERR;
				end else begin
					cmd.cap_fa = 1'b1; state_d = S_O2;
				end
			end
			S_O2: begin
				if (sts.o2_neg) state_d = S_WT;
				else if (sts.o2_bad) begin
					err_d = ST_INDEX; state_d = S_ERR;
				end else begin
					cmd.mem_rd = 1'b1; cmd.addr_sel = AS_O2; state_d = S_CK2;
				end
			end
			S_CK2: begin
				cmd.tgt_r = flip;
				if (sts.face_none) begin
					err_d = ST_BACKLINK; state_d = S_ERR;
				end else begin
					cmd.cap_fc = 1'b1; state_d = S_WT;
				end
			end
			S_WT: begin
				cmd.mem_wr = 1'b1; cmd.addr_sel = AS_T;
				cmd.wd_sel = flip ? WS_FT : WS_ST;
				if (flip) state_d = sts.o2_neg ? S_WR : S_P2R;
				else state_d = S_WN;
			end
			S_WN: begin
				cmd.mem_wr = 1'b1; cmd.addr_sel = AS_N; cmd.wd_sel = WS_SN;
				state_d = S_WN1;
			end
			S_WN1: begin
				cmd.mem_wr = 1'b1; cmd.addr_sel = AS_N1; cmd.wd_sel = WS_SN1;
				if (!sts.o1_neg) state_d = S_P1R;
				else state_d = sts.o2_neg ? S_FRD : S_P2R;
			end
			S_WR: begin
				cmd.mem_wr = 1'b1; cmd.addr_sel = AS_R; cmd.wd_sel = WS_FR;
				state_d = sts.o1_neg ? S_FRD : S_P1R;
			end
			// outer link repairs re-read the row so earlier writes are kept
			S_P1R: begin
				cmd.mem_rd = 1'b1; cmd.addr_sel = AS_O1;
				state_d = S_P1W;
			end
			S_P1W: begin
				cmd.mem_wr = 1'b1; cmd.addr_sel = AS_O1; cmd.wd_sel = WS_P1;
				if (flip || sts.o2_neg) state_d = S_FRD;
				else state_d = S_P2R;
			end
			S_P2R: begin
				cmd.mem_rd = 1'b1; cmd.addr_sel = AS_O2;
				state_d = S_P2W;
			end
			S_P2W: begin
				cmd.mem_wr = 1'b1; cmd.addr_sel = AS_O2; cmd.wd_sel = WS_P2;
				state_d = flip ? S_WR : S_FRD;
			end
			S_FRD: begin
				cmd.mem_rd   = 1'b1;
				cmd.addr_sel = (sts.op == OP_LOAD) ? AS_N : AS_T;
				state_d      = S_RES;
			end
			S_RES: if (sts.out_free) begin
				cmd.res_ok = 1'b1; state_d = S_IDLE;
			end
			S_ERR: if (sts.out_free) begin
				cmd.res_err  = 1'b1;
				cmd.err_code = err_q;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			err_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
		end
	end

`ifndef ASSERT_OFF
	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == S_DISP)
		else $error("request taken outside idle");
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_err |-> err_q != ST_OK)
		else $error("error response with ok status");
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_wr |-> !in_ready)
		else $error("table write while idle");
`endif

endmodule

// ===== design/triangle_mesh_edge_flip_split_top.sv =====
// Top level of the triangle mesh edge flip and split block.
// Usage:
//   req carries one request: load (append a triangle), read, flip an edge
//   of a triangle across a local face, or split a triangle 1-to-3 at a new
//   vertex. rsp returns one response per request: status, the triangle
//   count after the request and the addressed triangle (zeros on error).
//   One request is in work at a time; req.ready is high only when the
//   sequencer is idle, and it can be while a response still waits on rsp.
//   Every row read, row write and link repair goes through the single-port
//   row memory.
//   Reset clears the triangle count and the response valid flag; the table
//   rows hold nothing defined until written, and no clearing pass runs.
//   When rsp stalls, the finished response is held and the sequencer
//   waits at its last step before taking the next request.
module triangle_mesh_edge_flip_split_top import tmef_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tmef_req_if.sink   req,
	tmef_rsp_if.source rsp
);

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	assign req.ready = in_ready;

	tmef_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tmef_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp)
	);

endmodule

// ===== tb/tb_mesh_if.sv =====
`timescale 1ns / 100ps
// Testbench note: the block's channel interfaces live in design/; this file holds the scoreboard.
class mesh_scoreboard;
	tmef_pkg::rsp_t expected_q[$];
	int errors;

	function void note_request(tmef_pkg::rsp_t r);
		expected_q.push_back(r);
	endfunction

	task report(string what, int got, int exp_v);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
		errors++;
	endtask

	task check_response(tmef_pkg::rsp_t got);
		tmef_pkg::rsp_t e;
		if (expected_q.size() == 0) begin
			report("unexpected response", 1, 0);
			return;
		end
		e = expected_q.pop_front();
		if (got.status !== e.status) report("status", got.status, e.status);
		if (got.count_now !== e.count_now) report("count_now", got.count_now, e.count_now);
		if (got.out_vert0 !== e.out_vert0) report("out_vert0", got.out_vert0, e.out_vert0);
		if (got.out_vert1 !== e.out_vert1) report("out_vert1", got.out_vert1, e.out_vert1);
		if (got.out_vert2 !== e.out_vert2) report("out_vert2", got.out_vert2, e.out_vert2);
		if (got.out_link0 !== e.out_link0) report("out_link0", got.out_link0, e.out_link0);
		if (got.out_link1 !== e.out_link1) report("out_link1", got.out_link1, e.out_link1);
		if (got.out_link2 !== e.out_link2) report("out_link2", got.out_link2, e.out_link2);
	endtask
endclass

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top testbench: random and directed mesh requests checked against a local mesh model.
module tb_top;
	import tmef_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	always #5 clk = ~clk;

	tmef_req_if req();
	tmef_rsp_if rsp();

	triangle_mesh_edge_flip_split_top uut(.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	mesh_scoreboard sb = new();

	// local copy of the mesh
	vert_t mesh_v[MAX_TRIANGLES][3];
	int    mesh_l[MAX_TRIANGLES][3];
	int    mesh_count;
	int    send_idle_pct, recv_idle_pct;

	function automatic int wrap3(int x);
		return x % 3;
	endfunction

	function automatic int find_face(int row, int tgt);
		for (int k = 0; k < 3; k++) if (mesh_l[row][k] == tgt) return k;
		return 3;
	endfunction

	function automatic logic [2:0] outer_ok(int n, int back, output int face);
		face = 3;
		if (n < 0) return ST_OK;
		if (n >= mesh_count) return ST_INDEX;
		face = find_face(n, back);
		return (face == 3) ? ST_BACKLINK : ST_OK;
	endfunction

	function automatic rsp_t mesh_result(logic [2:0] st, bit show, int row);
		rsp_t o;
		o = '0;
		o.status = st;
		o.count_now = cnt_t'(mesh_count);
		if (show) begin
			o.out_vert0 = mesh_v[row][0];
			o.out_vert1 = mesh_v[row][1];
			o.out_vert2 = mesh_v[row][2];
			o.out_link0 = link_t'(mesh_l[row][0]);
			o.out_link1 = link_t'(mesh_l[row][1]);
			o.out_link2 = link_t'(mesh_l[row][2]);
		end
		return o;
	endfunction

	function automatic void set_row(int r, vert_t a, vert_t b, vert_t c, int x, int y, int z);
		mesh_v[r][0] = a; mesh_v[r][1] = b; mesh_v[r][2] = c;
		mesh_l[r][0] = x; mesh_l[r][1] = y; mesh_l[r][2] = z;
	endfunction

	function automatic rsp_t apply_request(req_t q);
		int t, f, r, j, a, b, c, d, fa, fc, n;
		vert_t v0, v1, v2, pv, w3;
		logic [2:0] st;
		t = q.tri_index;
		f = q.local_face;
		if (q.operation == OP_LOAD) begin
			n = mesh_count;
			if (n >= MAX_TRIANGLES) return mesh_result(ST_FULL, 0, 0);
			set_row(n, q.load_vert0, q.load_vert1, q.load_vert2,
				$signed(q.load_link0), $signed(q.load_link1), $signed(q.load_link2));
			mesh_count = n + 1;
			return mesh_result(ST_OK, 1, n);
		end
		if (t >= mesh_count) return mesh_result(ST_INDEX, 0, 0);
		if (q.operation == OP_READ) return mesh_result(ST_OK, 1, t);
		if (q.operation == OP_FLIP) begin
			if (f >= 3) return mesh_result(ST_INDEX, 0, 0);
			r = mesh_l[t][f];
			if (r < 0) return mesh_result(ST_BOUNDARY, 0, 0);
			if (r >= mesh_count) return mesh_result(ST_INDEX, 0, 0);
			j = find_face(r, t);
			if (j == 3) return mesh_result(ST_BACKLINK, 0, 0);
			v0 = mesh_v[t][f]; v1 = mesh_v[t][wrap3(f+1)]; v2 = mesh_v[t][wrap3(f+2)];
			a = mesh_l[t][wrap3(f+1)]; b = mesh_l[t][wrap3(f+2)];
			pv = mesh_v[r][wrap3(j+2)];
			c = mesh_l[r][wrap3(j+1)]; d = mesh_l[r][wrap3(j+2)];
			st = outer_ok(a, t, fa);
			if (st != ST_OK) return mesh_result(st, 0, 0);
			st = outer_ok(c, r, fc);
			if (st != ST_OK) return mesh_result(st, 0, 0);
			set_row(t, pv, v2, v0, r, b, c);
			if (c >= 0) mesh_l[c][fc] = t;
			set_row(r, pv, v1, v2, d, a, t);
			if (a >= 0) mesh_l[a][fa] = r;
			return mesh_result(ST_OK, 1, t);
		end
		n = mesh_count;
		if (n + 2 > MAX_TRIANGLES) return mesh_result(ST_FULL, 0, 0);
		v0 = mesh_v[t][0]; v1 = mesh_v[t][1]; w3 = mesh_v[t][2];
		a = mesh_l[t][0]; b = mesh_l[t][1]; c = mesh_l[t][2];
		st = outer_ok(b, t, fa);
		if (st != ST_OK) return mesh_result(st, 0, 0);
		st = outer_ok(c, t, fc);
		if (st != ST_OK) return mesh_result(st, 0, 0);
		set_row(t, q.new_vertex, v0, v1, n + 1, a, n);
		set_row(n, q.new_vertex, v1, w3, t, b, n + 1);
		set_row(n + 1, q.new_vertex, w3, v0, n, c, t);
		if (b >= 0) mesh_l[b][fa] = n;
		if (c >= 0) mesh_l[c][fc] = n + 1;
		mesh_count = n + 2;
		return mesh_result(ST_OK, 1, t);
	endfunction

	// mostly valid links into the stored range, some boundary, some junk
	function automatic link_t pick_link();
		int k;
		k = $urandom_range(0, 19);
		if (k < 4) return link_t'(-1);
		if (k == 5) return link_t'($urandom);
		if (mesh_count > 0 && k < 17) return link_t'($urandom_range(0, mesh_count - 1));
		return link_t'($urandom_range(0, 1023));
	endfunction

	function automatic req_t random_request();
		req_t q;
		int k;
		q = '0;
		q.new_vertex = vert_t'($urandom); q.load_vert0 = vert_t'($urandom);
		q.load_vert1 = vert_t'($urandom); q.load_vert2 = vert_t'($urandom);
		q.load_link0 = pick_link(); q.load_link1 = pick_link(); q.load_link2 = pick_link();
		q.local_face = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		k = $urandom_range(0, 9);
		q.operation = (k < 3) ? OP_LOAD : (k < 5) ? OP_READ : (k < 8) ? OP_FLIP : OP_SPLIT;
		if (mesh_count > 0 && $urandom_range(0, 9) != 0)
			q.tri_index = IDX_W'($urandom_range(0, mesh_count - 1));
		else
			q.tri_index = IDX_W'($urandom);
		return q;
	endfunction

	// valid stays up from one request to the next unless the sender idles
	task automatic send_request(req_t q);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= q;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sb.note_request(apply_request(q));
	endtask

	task automatic load_full(vert_t a, vert_t b, vert_t c, link_t x, link_t y, link_t z);
		req_t q;
		q = '0;
		q.operation = OP_LOAD;
		q.load_vert0 = a; q.load_vert1 = b; q.load_vert2 = c;
		q.load_link0 = x; q.load_link1 = y; q.load_link2 = z;
		send_request(q);
	endtask

	task automatic op_on(logic [1:0] op, int t, int f, vert_t p);
		req_t q;
		q = '0;
		q.operation = op; q.tri_index = IDX_W'(t); q.local_face = 2'(f); q.new_vertex = p;
		send_request(q);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready) sb.check_response(rsp.data);
			rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		req.valid = 0;
		req.data = '0;
		rsp.ready = 0;
		mesh_count = 0;
		send_idle_pct = 8;
		recv_idle_pct = 50;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: errors on empty table, a pair of linked triangles, flips, splits
		op_on(OP_READ, 0, 0, 0);
		op_on(OP_FLIP, 1023, 0, 0);
		load_full(16'h0000, 16'hFFFF, 16'h5555, 11'd1, -11'sd1, -11'sd1);
		load_full(16'hAAAA, 16'h5555, 16'hFFFF, 11'd0, 11'h3FF, 11'h400);
		op_on(OP_READ, 1, 0, 0);
		op_on(OP_FLIP, 0, 3, 0);
		op_on(OP_FLIP, 0, 1, 0);
		op_on(OP_FLIP, 1, 1, 0);
		op_on(OP_FLIP, 1, 2, 0);
		op_on(OP_SPLIT, 1, 0, 16'hFFFF);
		op_on(OP_FLIP, 0, 0, 0);
		load_full(16'd1, 16'd2, 16'd3, 11'd0, 11'd2, -11'sd1);
		load_full(16'd4, 16'd5, 16'd6, 11'd3, -11'sd1, 11'd9);
		op_on(OP_SPLIT, 2, 0, 16'h1234);
		op_on(OP_FLIP, 0, 0, 0);
		op_on(OP_SPLIT, 0, 0, 16'h0000);
		op_on(OP_SPLIT, 3, 0, 16'h7);
		op_on(OP_READ, 1023, 0, 0);

		for (int i = 0; i < 550; i++) begin
			if (i == 180) begin send_idle_pct = 50; recv_idle_pct = 8; end
			if (i == 360) begin send_idle_pct = 0; recv_idle_pct = 0; end
			send_request(random_request());
		end
		load_full(1, 2, 3, 0, 0, 0);
		op_on(OP_SPLIT, 0, 0, 5);
		op_on(OP_READ, 1023, 0, 0);
		req.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_top failed");
		$finish;
	end
endmodule
